FILE: sv/vpa_pkg.sv
// Package for the variable partition allocator: payload structs, codes, FSM states.
// No dependencies.
package vpa_pkg;

   localparam int DefMaxProcs = 32;
   localparam int DefAddrBits = 16;
   localparam int DefIdBits   = 8;

   localparam logic [15:0] RESET_TOTAL = 16'd1024;
   localparam logic [15:0] RESET_SLICE = 16'd10;

   typedef enum logic [1:0] {
      CSR_TOTAL = 2'd0,
      CSR_POLICY = 2'd1,
      CSR_SLICE = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      FIT_FIRST = 2'd0,
      FIT_BEST  = 2'd1,
      FIT_WORST = 2'd2
   } fit_type;

   typedef enum logic [2:0] {
      ST_GRANTED   = 3'd0,
      ST_RELOCATED = 3'd1,
      ST_RELEASED  = 3'd2,
      ST_NO_SPACE  = 3'd3,
      ST_NOT_FOUND = 3'd4,
      ST_BAD_SIZE  = 3'd5
   } status_type;

   typedef struct packed {
      logic        action;
      logic [15:0] req_size;
      logic [7:0]  proc_id;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  owner_id;
      logic [15:0] base_addr;
      logic [15:0] block_size;
      logic        last;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_INIT,
      S_FIT_SCAN,
      S_FIT_DONE,
      S_CMP_SCAN,
      S_CMP_PLACE,
      S_CMP_FINISH,
      S_GRANT,
      S_REL_FIND,
      S_REL_SCAN,
      S_REL_DONE,
      S_REPLY
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic init;       // latch request, clear scan
      logic scan_step;  // one table entry per cycle
      logic fit_done;   // evaluate fit result
      logic cmp_start;  // start a compaction selection round
      logic cmp_place;  // place selected owner
      logic cmp_finish; // rebuild free table
      logic grant;
      logic rel_find;
      logic rel_done;
      logic reply;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic rel_req;      // latched request is a release
      logic scan_end;
      logic early_exit;   // request resolved with one reply
      logic fit_found;
      logic can_compact;
      logic compacted;    // already compacted once
      logic cmp_any;      // a block selected this round
      logic rel_found;
   } stat_type;

endpackage

FILE: sv/vpa_ctrl.sv
// Controller state machine for the variable partition allocator.
// Depends on vpa_pkg.
module vpa_ctrl import vpa_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  stat_type stat,
   output logic     busy,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (start) state_in = S_INIT;
         S_INIT: begin
            if (stat.rel_req) state_in = S_REL_FIND;
            else if (stat.early_exit) state_in = S_REPLY;
            else state_in = S_FIT_SCAN;
         end
         S_FIT_SCAN: if (stat.scan_end) state_in = S_FIT_DONE;
         S_FIT_DONE: begin
            if (stat.fit_found) state_in = S_GRANT;
            else if (stat.can_compact && !stat.compacted) state_in = S_CMP_SCAN;
            else state_in = S_REPLY;
         end
         S_CMP_SCAN: begin
            if (stat.scan_end) begin
               if (stat.cmp_any) state_in = S_CMP_PLACE;
               else state_in = S_CMP_FINISH;
            end
         end
         S_CMP_PLACE: state_in = S_CMP_SCAN;
         S_CMP_FINISH: state_in = S_FIT_SCAN;
         S_GRANT: state_in = S_REPLY;
         S_REL_FIND: begin
            if (stat.scan_end) begin
               if (stat.rel_found) state_in = S_REL_SCAN;
               else state_in = S_REPLY;
            end
         end
         S_REL_SCAN: if (stat.scan_end) state_in = S_REL_DONE;
         S_REL_DONE: state_in = S_REPLY;
         S_REPLY: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      busy = (state_ff != S_IDLE);
      unique case (state_ff)
         S_IDLE: cmd.init = start;
         S_FIT_SCAN, S_REL_SCAN: cmd.scan_step = 1'b1;
         S_REL_FIND: begin
            cmd.scan_step = 1'b1;
            cmd.rel_find = 1'b1;
         end
         S_FIT_DONE: cmd.fit_done = 1'b1;
         S_CMP_SCAN: begin
            cmd.scan_step = 1'b1;
            cmd.cmp_start = 1'b1;
         end
         S_CMP_PLACE: cmd.cmp_place = 1'b1;
         S_CMP_FINISH: cmd.cmp_finish = 1'b1;
         S_GRANT: cmd.grant = 1'b1;
         S_REL_DONE: cmd.rel_done = 1'b1;
         S_REPLY: cmd.reply = 1'b1;
         default: ;
      endcase
   end

endmodule

FILE: sv/vpa_dp.sv
// Datapath for the variable partition allocator: free and owner tables,
// sequential scans, compaction placement and result register. Depends on vpa_pkg.
module vpa_dp import vpa_pkg::*; #(
   parameter int MAX_PROCS = DefMaxProcs
) (
   input  logic           clock,
   input  logic           reset,
   input  cmd_type        cmd,
   input  req_type        req,
   input  logic           cfg_we,
   input  logic [1:0]     cfg_index,
   input  logic [15:0]    cfg_data,
   output stat_type       stat,
   output logic           rsp_strobe,
   output rsp_type        rsp_data
);

   localparam int ADDR_BITS = DefAddrBits;
   localparam int ID_BITS   = DefIdBits;
   localparam int FreeDepth = MAX_PROCS + 1;
   localparam int IdxBits   = $clog2(FreeDepth + 1);
   localparam int OwnBits   = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;

   logic [ADDR_BITS-1:0] total_ff, slice_ff;
   logic [1:0]           policy_ff;
   logic [ID_BITS-1:0]   tag_ff;

   logic [ADDR_BITS-1:0] fstart_ff [FreeDepth];
   logic [ADDR_BITS-1:0] flen_ff   [FreeDepth];
   logic [FreeDepth-1:0] fused_ff;
   logic [ID_BITS-1:0]   otag_ff   [MAX_PROCS];
   logic [ADDR_BITS-1:0] ostart_ff [MAX_PROCS];
   logic [ADDR_BITS-1:0] olen_ff   [MAX_PROCS];
   logic [MAX_PROCS-1:0] oused_ff, placed_ff;

   req_type              req_ff;
   logic [ID_BITS-1:0]   id_ff;
   logic [IdxBits-1:0]   cnt_ff;
   logic                 best_ok_ff, compacted_ff, sel_ok_ff, left_ok_ff, right_ok_ff;
   logic [IdxBits-1:0]   best_ff, left_ff, right_ff;
   logic [ADDR_BITS-1:0] best_start_ff, best_len_ff, left_len_ff, right_len_ff;
   logic [OwnBits-1:0]   slot_ff, sel_ff;
   logic                 slot_ok_ff;
   logic [ADDR_BITS:0]   sum_ff;
   logic [ADDR_BITS-1:0] cursor_ff;
   logic                 vld_ff;
   rsp_type              rsp_ff;

   // free table read stage: one entry per scan cycle, evaluated in the next cycle
   logic                 rd_ok_ff;
   logic [IdxBits-1:0]   rd_idx_ff;
   logic [ADDR_BITS-1:0] rd_start_ff, rd_len_ff;

   // scan element
   logic [IdxBits-1:0] ci;
   logic [OwnBits-1:0] co;
   logic               in_free, in_own, scan_rd;
   assign ci      = cnt_ff;
   assign co      = cnt_ff[OwnBits-1:0];
   assign in_free = (cnt_ff < IdxBits'(FreeDepth));
   assign in_own  = (cnt_ff < IdxBits'(MAX_PROCS));
   assign scan_rd = cmd.scan_step && !cmd.cmp_start && !cmd.rel_find && in_free;

   logic [ADDR_BITS-1:0] fs_i, fl_i, fs_b, fl_b, req_a;
   logic                 fu_i, take, fits;
   assign fs_i  = rd_start_ff;
   assign fl_i  = rd_len_ff;
   assign fu_i  = rd_ok_ff;
   assign fs_b  = best_start_ff;
   assign fl_b  = best_len_ff;
   assign req_a = ADDR_BITS'(req_ff.req_size);
   assign fits  = fu_i && (fl_i >= req_a);

   always_comb begin
      case (fit_type'(policy_ff))
         FIT_BEST:  take = (fl_i < fl_b) || ((fl_i == fl_b) && (fs_i < fs_b));
         FIT_WORST: take = (fl_i > fl_b) || ((fl_i == fl_b) && (fs_i < fs_b));
         default:   take = fs_i < fs_b;
      endcase
   end

   logic [ADDR_BITS-1:0] leftover, rel_s, rel_l, rel_e;
   assign leftover = fl_b - req_a;
   assign rel_s = ostart_ff[sel_ff];
   assign rel_l = olen_ff[sel_ff];
   assign rel_e = rel_s + rel_l;

   logic [IdxBits-1:0] free_slot;
   logic               free_slot_ok;
   always_comb begin
      free_slot = '0;
      free_slot_ok = 1'b0;
      for (int i = FreeDepth - 1; i >= 0; i--) begin
         if (!fused_ff[i]) begin
            free_slot = IdxBits'(i);
            free_slot_ok = 1'b1;
         end
      end
   end

   logic [OwnBits-1:0] own_slot;
   logic               own_slot_ok;
   always_comb begin
      own_slot = '0;
      own_slot_ok = 1'b0;
      for (int i = MAX_PROCS - 1; i >= 0; i--) begin
         if (!oused_ff[i]) begin
            own_slot = OwnBits'(i);
            own_slot_ok = 1'b1;
         end
      end
   end

   logic [ID_BITS-1:0] tag_next;
   assign tag_next = tag_ff + 1'b1;

   assign stat.rel_req     = req_ff.action;
   assign stat.scan_end    = (cnt_ff == IdxBits'(FreeDepth));
   assign stat.early_exit  = !slot_ok_ff || (req_ff.req_size == '0);
   assign stat.fit_found   = best_ok_ff;
   assign stat.can_compact = (sum_ff >= {1'b0, req_a});
   assign stat.compacted   = compacted_ff;
   assign stat.cmp_any     = sel_ok_ff;
   assign stat.rel_found   = sel_ok_ff;

   always_ff @(posedge clock) begin
      vld_ff <= 1'b0;
      rd_ok_ff <= scan_rd && fused_ff[ci];
      if (scan_rd) begin
         rd_idx_ff <= ci;
         rd_start_ff <= fstart_ff[ci];
         rd_len_ff <= flen_ff[ci];
      end
      if (cmd.scan_step) cnt_ff <= cnt_ff + 1'b1;
      if (cmd.init) begin
         req_ff <= req;
         cnt_ff <= '0;
         best_ok_ff <= 1'b0;
         best_ff <= '0;
         sum_ff <= '0;
         sel_ok_ff <= 1'b0;
         sel_ff <= '0;
         compacted_ff <= 1'b0;
         left_ok_ff <= 1'b0;
         right_ok_ff <= 1'b0;
         slot_ff <= own_slot;
         slot_ok_ff <= own_slot_ok;
         if (!req.action) begin
            tag_ff <= tag_next;
            id_ff <= tag_next;
         end
      end
      // first-fit/best/worst scan and free-sum for allocations, neighbour search for releases, on the registered entry
      if (fu_i) begin
         if (req_ff.action) begin
            if (!left_ok_ff && (fs_i + fl_i == rel_s)) begin
               left_ok_ff <= 1'b1;
               left_ff <= rd_idx_ff;
               left_len_ff <= fl_i;
            end else if (!right_ok_ff && (fs_i == rel_e)) begin
               right_ok_ff <= 1'b1;
               right_ff <= rd_idx_ff;
               right_len_ff <= fl_i;
            end
         end else begin
            sum_ff <= sum_ff + {1'b0, fl_i};
            if (fits && (!best_ok_ff || take)) begin
               best_ok_ff <= 1'b1;
               best_ff <= rd_idx_ff;
               best_start_ff <= fs_i;
               best_len_ff <= fl_i;
            end
         end
      end
      if (cmd.rel_find && in_own && !sel_ok_ff && oused_ff[co]
          && (otag_ff[co] == ID_BITS'(req_ff.proc_id))) begin
         sel_ok_ff <= 1'b1;
         sel_ff <= co;
      end
      if (cmd.rel_find && stat.scan_end) cnt_ff <= '0;
      // compaction: select lowest unplaced owner
      if (cmd.cmp_start && in_own && oused_ff[co] && !placed_ff[co]
          && (!sel_ok_ff || ostart_ff[co] < ostart_ff[sel_ff])) begin
         sel_ok_ff <= 1'b1;
         sel_ff <= co;
      end
      if (cmd.fit_done && !best_ok_ff) begin
         cnt_ff <= '0;
         sel_ok_ff <= 1'b0;
         placed_ff <= '0;
         cursor_ff <= '0;
      end
      if (cmd.cmp_place) begin
         placed_ff[sel_ff] <= 1'b1;
         if (ostart_ff[sel_ff] != cursor_ff) begin
            ostart_ff[sel_ff] <= cursor_ff;
            vld_ff <= 1'b1;
            rsp_ff <= '{status: ST_RELOCATED, owner_id: 8'(otag_ff[sel_ff]),
                        base_addr: 16'(cursor_ff), block_size: 16'(olen_ff[sel_ff]),
                        last: 1'b0};
         end
         cursor_ff <= cursor_ff + olen_ff[sel_ff];
         sel_ok_ff <= 1'b0;
         cnt_ff <= '0;
      end
      if (cmd.cmp_finish) begin
         compacted_ff <= 1'b1;
         cnt_ff <= '0;
         best_ok_ff <= 1'b0;
         sum_ff <= '0;
         fused_ff <= '0;
         if (total_ff > cursor_ff) begin
            fused_ff[0] <= 1'b1;
            fstart_ff[0] <= cursor_ff;
            flen_ff[0] <= total_ff - cursor_ff;
         end
      end
      if (cmd.grant) begin
         if (leftover <= slice_ff) begin
            fused_ff[best_ff] <= 1'b0;
         end else begin
            fstart_ff[best_ff] <= fs_b + req_a;
            flen_ff[best_ff] <= leftover;
         end
         oused_ff[slot_ff] <= 1'b1;
         otag_ff[slot_ff] <= id_ff;
         ostart_ff[slot_ff] <= fs_b;
         olen_ff[slot_ff] <= (leftover <= slice_ff) ? fl_b : req_a;
      end
      if (cmd.rel_done) begin
         oused_ff[sel_ff] <= 1'b0;
         if (left_ok_ff) begin
            flen_ff[left_ff] <= left_len_ff + rel_l
                                + (right_ok_ff ? right_len_ff : '0);
            if (right_ok_ff) fused_ff[right_ff] <= 1'b0;
         end else if (right_ok_ff) begin
            fstart_ff[right_ff] <= rel_s;
            flen_ff[right_ff] <= right_len_ff + rel_l;
         end else if (free_slot_ok) begin
            fused_ff[free_slot] <= 1'b1;
            fstart_ff[free_slot] <= rel_s;
            flen_ff[free_slot] <= rel_l;
         end
      end
      if (cmd.reply) begin
         vld_ff <= 1'b1;
         rsp_ff.last <= 1'b1;
         rsp_ff.base_addr <= '0;
         rsp_ff.block_size <= '0;
         if (req_ff.action) begin
            rsp_ff.owner_id <= req_ff.proc_id;
            if (sel_ok_ff) begin
               rsp_ff.status <= ST_RELEASED;
               rsp_ff.base_addr <= 16'(rel_s);
               rsp_ff.block_size <= 16'(rel_l);
            end else begin
               rsp_ff.status <= ST_NOT_FOUND;
            end
         end else begin
            rsp_ff.owner_id <= 8'(id_ff);
            if (req_ff.req_size == '0) rsp_ff.status <= ST_BAD_SIZE;
            else if (!slot_ok_ff || !best_ok_ff) rsp_ff.status <= ST_NO_SPACE;
            else begin
               rsp_ff.status <= ST_GRANTED;
               rsp_ff.base_addr <= 16'(ostart_ff[slot_ff]);
               rsp_ff.block_size <= 16'(olen_ff[slot_ff]);
            end
         end
      end
      if (cfg_we) begin
         case (csr_index_type'(cfg_index))
            CSR_TOTAL: begin
               total_ff <= ADDR_BITS'(cfg_data);
               oused_ff <= '0;
               fused_ff <= '0;
               fstart_ff[0] <= '0;
               flen_ff[0] <= ADDR_BITS'(cfg_data);
               if (cfg_data != '0) fused_ff[0] <= 1'b1;
            end
            CSR_POLICY: policy_ff <= cfg_data[1:0];
            CSR_SLICE:  slice_ff <= ADDR_BITS'(cfg_data);
            default: ;
         endcase
      end
      if (reset) begin
         vld_ff <= 1'b0;
         rd_ok_ff <= 1'b0;
         total_ff <= ADDR_BITS'(RESET_TOTAL);
         slice_ff <= ADDR_BITS'(RESET_SLICE);
         policy_ff <= FIT_FIRST;
         tag_ff <= '0;
         oused_ff <= '0;
         fused_ff <= '0;
         fused_ff[0] <= 1'b1;
         fstart_ff[0] <= '0;
         flen_ff[0] <= ADDR_BITS'(RESET_TOTAL);
      end
   end

   assign rsp_strobe = vld_ff;
   assign rsp_data   = rsp_ff;

endmodule

FILE: sv/variable_partition_allocator.sv
// Variable partition allocator: first/best/worst fit with compaction.
// Compaction sends one relocation result per block that moves, ahead of the final reply.
// Throughput: one request at a time; busy falls in the cycle of the last result.
// Synchronous reset restores total_size 1024, first fit, slice limit 10, empty owners.
module variable_partition_allocator import vpa_pkg::*; #(
   parameter int MAX_PROCS = DefMaxProcs
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_strobe,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = !busy && !start;

   vpa_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start),
      .stat(stat), .busy(busy), .cmd(cmd)
   );

   vpa_dp #(.MAX_PROCS(MAX_PROCS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .req(req_data),
      .cfg_we(csr_valid && csr_ready), .cfg_index(csr_index), .cfg_data(csr_data),
      .stat(stat), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.last |-> !busy) else $error("busy after last result");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("request not taken");
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.last |-> busy) else $error("relocation outside request");

endmodule

FILE: tb/variable_partition_allocator_tb.sv
// Self-checking testbench for variable_partition_allocator: directed and random requests
// across several CSR settings, checked against an in-bench allocator predictor.
// Depends on vpa_pkg and the variable_partition_allocator RTL.
module variable_partition_allocator_tb;
   import vpa_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NPROC = 32;
   localparam int NFREE = NPROC + 1;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int PHASE_ITEMS = 30;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_data = '0;
   logic        rsp_strobe;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_TOTAL;
   logic [15:0] csr_data = '0;

   variable_partition_allocator dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_data(csr_data)
   );

   initial forever #10 clock = ~clock;

   // allocator shadow state
   int unsigned mem_total = RESET_TOTAL;
   logic [1:0]  fit_mode = FIT_FIRST;
   int unsigned slice_max = RESET_SLICE;
   int unsigned tag_ctr = 0;
   int unsigned hole_start[NFREE], hole_len[NFREE];
   bit          hole_used[NFREE];
   int unsigned part_tag[NPROC], part_start[NPROC], part_len[NPROC];
   bit          part_used[NPROC];

   req_type pend_q[$];
   rsp_type result_q[$];
   int      idle_pct = 0;
   int      err_count = 0;
   int      n_items = 0, n_results = 0, n_moves = 0, n_nospace = 0;
   int      stall_cnt = 0;

   task automatic report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      err_count++;
   endtask

   function automatic void push_result(status_type st, int unsigned id, int unsigned addr,
                                       int unsigned size);
      rsp_type r;
      r.status = st;
      r.owner_id = id[7:0];
      r.base_addr = addr[15:0];
      r.block_size = size[15:0];
      r.last = (st != ST_RELOCATED);
      result_q.push_back(r);
   endfunction

   function automatic void clear_tables();
      for (int i = 0; i < NPROC; i++) begin
         part_used[i] = 0; part_tag[i] = 0; part_start[i] = 0; part_len[i] = 0;
      end
      for (int i = 0; i < NFREE; i++) begin
         hole_used[i] = 0; hole_start[i] = 0; hole_len[i] = 0;
      end
      if (mem_total > 0) begin
         hole_used[0] = 1;
         hole_len[0] = mem_total;
      end
   endfunction

   function automatic int pick_hole(int unsigned req);
      int  best = -1;
      bit  take;
      for (int i = 0; i < NFREE; i++) begin
         if (!hole_used[i] || hole_len[i] < req) continue;
         if (best < 0) begin
            best = i;
            continue;
         end
         // ties always go to the lower address
         if (fit_mode == FIT_BEST)
            take = hole_len[i] < hole_len[best] ||
                   (hole_len[i] == hole_len[best] && hole_start[i] < hole_start[best]);
         else if (fit_mode == FIT_WORST)
            take = hole_len[i] > hole_len[best] ||
                   (hole_len[i] == hole_len[best] && hole_start[i] < hole_start[best]);
         else
            take = hole_start[i] < hole_start[best];
         if (take) best = i;
      end
      return best;
   endfunction

   function automatic void pack_partitions();
      bit          placed[NPROC];
      int unsigned cursor = 0;
      int          sel;
      for (int i = 0; i < NPROC; i++) placed[i] = 0;
      for (int round = 0; round < NPROC; round++) begin
         sel = -1;
         for (int i = 0; i < NPROC; i++)
            if (part_used[i] && !placed[i] && (sel < 0 || part_start[i] < part_start[sel]))
               sel = i;
         if (sel < 0) break;
         placed[sel] = 1;
         if (part_start[sel] != cursor) begin
            part_start[sel] = cursor;
            push_result(ST_RELOCATED, part_tag[sel], cursor, part_len[sel]);
         end
         cursor = (cursor + part_len[sel]) & 16'hFFFF;
      end
      for (int i = 0; i < NFREE; i++) hole_used[i] = 0;
      if (mem_total > cursor) begin
         hole_used[0] = 1;
         hole_start[0] = cursor;
         hole_len[0] = (mem_total - cursor) & 16'hFFFF;
      end
   endfunction

   function automatic void predict_alloc(int unsigned req);
      int unsigned id, sum = 0, leftover, gstart, gsize;
      int          slot = -1, f;
      tag_ctr = (tag_ctr + 1) & 8'hFF;
      id = tag_ctr;
      if (req == 0) begin
         push_result(ST_BAD_SIZE, id, 0, 0);
         return;
      end
      for (int i = 0; i < NPROC; i++)
         if (!part_used[i]) begin
            slot = i;
            break;
         end
      if (slot < 0) begin
         push_result(ST_NO_SPACE, id, 0, 0);
         return;
      end
      f = pick_hole(req);
      if (f < 0) begin
         for (int i = 0; i < NFREE; i++) if (hole_used[i]) sum += hole_len[i];
         if (sum >= req) begin
            pack_partitions();
            f = pick_hole(req);
         end
      end
      if (f < 0) begin
         push_result(ST_NO_SPACE, id, 0, 0);
         return;
      end
      gstart = hole_start[f];
      leftover = hole_len[f] - req;
      if (leftover <= slice_max) begin
         gsize = hole_len[f];
         hole_used[f] = 0; hole_start[f] = 0; hole_len[f] = 0;
      end else begin
         gsize = req;
         hole_start[f] = (hole_start[f] + req) & 16'hFFFF;
         hole_len[f] = leftover;
      end
      part_used[slot] = 1;
      part_tag[slot] = id;
      part_start[slot] = gstart;
      part_len[slot] = gsize;
      push_result(ST_GRANTED, id, gstart, gsize);
   endfunction

   function automatic void predict_release(int unsigned pid);
      int          sel = -1, lft = -1, rgt = -1;
      int unsigned s, l, e;
      for (int i = 0; i < NPROC; i++)
         if (part_used[i] && part_tag[i] == pid) begin
            sel = i;
            break;
         end
      if (sel < 0) begin
         push_result(ST_NOT_FOUND, pid, 0, 0);
         return;
      end
      s = part_start[sel];
      l = part_len[sel];
      e = s + l;
      part_used[sel] = 0;
      for (int i = 0; i < NFREE; i++) begin
         if (!hole_used[i]) continue;
         if (hole_start[i] + hole_len[i] == s && lft < 0) lft = i;
         else if (hole_start[i] == e && rgt < 0) rgt = i;
      end
      if (lft >= 0) begin
         hole_len[lft] = (hole_len[lft] + l) & 16'hFFFF;
         if (rgt >= 0) begin
            hole_len[lft] = (hole_len[lft] + hole_len[rgt]) & 16'hFFFF;
            hole_used[rgt] = 0;
         end
      end else if (rgt >= 0) begin
         hole_start[rgt] = s;
         hole_len[rgt] = (hole_len[rgt] + l) & 16'hFFFF;
      end else begin
         for (int i = 0; i < NFREE; i++)
            if (!hole_used[i]) begin
               hole_used[i] = 1; hole_start[i] = s; hole_len[i] = l;
               break;
            end
      end
      push_result(ST_RELEASED, pid, s, l);
   endfunction

   // driver: one transaction per start && !busy edge
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            if (req_data.action) predict_release(req_data.proc_id);
            else predict_alloc(req_data.req_size);
            void'(pend_q.pop_front());
            n_items++;
         end
         if (start && busy) begin
            start <= 1'b1;
         end else if (pend_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
            start <= 1'b1;
            req_data <= pend_q[0];
         end else begin
            start <= 1'b0;
         end
      end
   end

   task automatic check_field(string name, int got, int want);
      if (got != want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
   endtask

   // monitor: results cannot be held off, every strobe is a transaction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         n_results++;
         if (rsp_data.status == ST_RELOCATED) n_moves++;
         if (rsp_data.status == ST_NO_SPACE) n_nospace++;
         if (result_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result status %0d id %0d",
                                      rsp_data.status, rsp_data.owner_id));
         end else begin
            want = result_q.pop_front();
            check_field("status", rsp_data.status, want.status);
            check_field("owner_id", rsp_data.owner_id, want.owner_id);
            check_field("base_addr", rsp_data.base_addr, want.base_addr);
            check_field("block_size", rsp_data.block_size, want.block_size);
            check_field("last", rsp_data.last, want.last);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready)) begin
         stall_cnt <= 0;
      end else begin
         stall_cnt <= stall_cnt + 1;
         if (stall_cnt >= WATCHDOG_LIMIT) begin
            $display("watchdog expired after %0d idle cycles", stall_cnt);
            $display("variable_partition_allocator regression: fail");
            $finish;
         end
      end
   end

   task automatic write_csr(csr_index_type idx, logic [15:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_TOTAL: begin
            mem_total = val;
            clear_tables();
         end
         CSR_POLICY: fit_mode = val[1:0];
         default: slice_max = val;
      endcase
   endtask

   task automatic drain();
      while (pend_q.size() != 0 || start || busy || result_q.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic push_req(bit act, int unsigned size, int unsigned pid);
      req_type r;
      r.action = act;
      r.req_size = size[15:0];
      r.proc_id = pid[7:0];
      pend_q.push_back(r);
   endtask

   // random item built from the current shadow state
   task automatic gen_item();
      int          r, kind, nlive = 0, pick, biggest = 0;
      int unsigned size;
      r = $urandom_range(99);
      for (int i = 0; i < NPROC; i++) if (part_used[i]) nlive++;
      if (r < 8) begin
         pend_q.push_back(req_type'($urandom));
      end else if (r < 42) begin
         if (nlive == 0) begin
            push_req(1'b1, $urandom, $urandom_range(255));
         end else begin
            pick = $urandom_range(nlive - 1);
            for (int i = 0; i < NPROC; i++)
               if (part_used[i]) begin
                  if (pick == 0) push_req(1'b1, $urandom, part_tag[i]);
                  pick--;
               end
         end
      end else begin
         kind = $urandom_range(9);
         for (int i = 0; i < NFREE; i++)
            if (hole_used[i] && hole_len[i] > biggest) biggest = hole_len[i];
         case (kind)
            0: size = 0;
            1: size = $urandom_range(65535);
            2: size = biggest;
            3, 4, 5, 6: size = $urandom_range(mem_total / 40 + 1, 1);
            default: size = $urandom_range(mem_total / 6 + 1, 1);
         endcase
         push_req(1'b0, size, $urandom_range(255));
      end
   endtask

   initial begin
      int unsigned totals[7] = '{65535, 300, 1, 2000, 65535, 512, 4096};
      int unsigned slices[7] = '{0, 65535, 0, 5, 100, 3, 0};
      fit_type     pols[7] = '{FIT_BEST, FIT_WORST, FIT_FIRST, FIT_FIRST, FIT_WORST,
                               FIT_BEST, FIT_FIRST};
      int          idles[7] = '{65, 31, 0, 65, 31, 0, 65};
      clear_tables();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: bad size, too big, splits, whole grant, compaction, misses, exact fit
      push_req(0, 0, 0);        // id 1
      push_req(0, 65535, 255);  // id 2
      push_req(0, 100, 0);      // id 3
      push_req(0, 200, 0);      // id 4
      push_req(0, 100, 0);      // id 5
      push_req(0, 1, 0);        // id 6
      push_req(1, 0, 3);
      push_req(1, 0, 5);
      push_req(0, 700, 0);      // id 7, compacts
      push_req(1, 65535, 4);
      push_req(1, 0, 255);
      push_req(1, 0, 0);
      push_req(0, 113, 0);      // id 8
      push_req(0, 87, 0);       // id 9, exact fit
      push_req(0, 128, 0);      // id 10, no space
      push_req(0, 1023, 0);
      drain();

      // fit_mode 3 is exercised once as an unknown policy
      write_csr(CSR_POLICY, 2'd3);
      for (int n = 0; n < 10; n++) begin
         while (pend_q.size() != 0) @(posedge clock);
         gen_item();
      end
      drain();

      for (int ph = 0; ph < 7; ph++) begin
         write_csr(CSR_TOTAL, totals[ph]);
         write_csr(CSR_POLICY, pols[ph]);
         write_csr(CSR_SLICE, slices[ph]);
         idle_pct = idles[ph];
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            while (pend_q.size() != 0) @(posedge clock);
            gen_item();
         end
         drain();
      end

      $display("covered %0d requests over 9 CSR settings: %0d results, %0d relocations,",
               n_items, n_results, n_moves);
      $display("%0d no-space replies, mismatches %0d", n_nospace, err_count);
      if (result_q.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", result_q.size()));
      if (err_count == 0)
         $display("variable_partition_allocator regression: pass");
      else
         $display("variable_partition_allocator regression: fail");
      $finish;
   end
endmodule
